@@ design/adclcd_pkg.sv @@
// ----------------------------------------------------------------------------
// adclcd_pkg
// Shared types and constants for the converter word to display readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adclcd_pkg;

    // Number of decimal digits shown (4 to 10)
    localparam int DIGITS     = 7;
    // Writes per refresh run: command, DIGITS digits and the point
    localparam int N_WRITES   = DIGITS + 2;
    localparam int IDX_W      = $clog2(N_WRITES);
    localparam int BCD_W      = 4 * DIGITS;
    // The point follows this many digits
    localparam int DOT_POS    = 3;

    localparam int WORD_W     = 16;
    // 5 * 10000 folded into one factor; 65535 * 50000 < 2^32
    localparam int SCALE_MUL  = 5 * 10000;
    localparam int PROD_W     = 32;
    // Divisor is 2^DIV_SH - 1, so the high part folds back onto the low part
    localparam int DIV_SH     = 10;
    localparam int SCALE_DIV  = (1 << DIV_SH) - 1;
    // Quotient width; the largest quotient is 3203079
    localparam int Q_W        = PROD_W - DIV_SH;
    localparam int CNT_W      = $clog2(Q_W);

    localparam logic [7:0] HOME_CMD  = 8'h80;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] ZERO_CHAR = 8'h30;

    // Input beat
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       ninth_bit;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       lcd_rs;
        logic       last;
    } t_out_item;

    // Word handed from the front to the queue / from the queue to the back
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_word_beat;

endpackage

`default_nettype wire

@@ design/adclcd_front.sv @@
// ----------------------------------------------------------------------------
// adclcd_front
// Takes input beats, merges the byte into the stored converter word and
// pushes the updated word towards the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adclcd_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  adclcd_pkg::t_in_item    i_in_data,
    input  wire                     i_q_full,
    output adclcd_pkg::t_word_beat  o_push
);

    logic [7:0] r_word_low;
    logic [7:0] r_word_high;
    logic       w_take;

    assign o_in_ready = !i_q_full;
    assign w_take     = i_in_valid && !i_q_full;

    // Ninth bit set: low byte, else high byte
    always_comb begin
        o_push.valid = w_take;
        if (i_in_data.ninth_bit) begin
            o_push.word = {r_word_high, i_in_data.rx_byte};
        end else begin
            o_push.word = {i_in_data.rx_byte, r_word_low};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_low  <= '0;
            r_word_high <= '0;
        end else if (w_take) begin
            if (i_in_data.ninth_bit) begin
                r_word_low <= i_in_data.rx_byte;
            end else begin
                r_word_high <= i_in_data.rx_byte;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/adclcd_queue.sv @@
// ----------------------------------------------------------------------------
// adclcd_queue
// Two-entry word queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adclcd_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  adclcd_pkg::t_word_beat  i_push,
    output logic                    o_full,
    input  wire                     i_pop,
    output adclcd_pkg::t_word_beat  o_head
);

    logic [adclcd_pkg::WORD_W-1:0] r_mem [2];
    logic                          r_wptr;
    logic                          r_rptr;
    logic [1:0]                    r_count;
    logic                          w_pop;

    assign o_full      = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.word  = r_mem[r_rptr];
    assign w_pop       = i_pop && o_head.valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.word;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push.valid && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !i_push.valid) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/adclcd_back.sv @@
// ----------------------------------------------------------------------------
// adclcd_back
// Scales a word by 50000/1023, folding the product by 2^10 - 1 in repeated
// steps, converts the quotient with shift-and-add-3 and plays out the
// display writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adclcd_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  adclcd_pkg::t_word_beat  i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output adclcd_pkg::t_out_item   o_out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_CONV,
        ST_EMIT
    } t_state;

    t_state                            r_state;
    logic [adclcd_pkg::PROD_W-1:0]     r_prod;
    logic [adclcd_pkg::Q_W-1:0]        r_quo;
    logic [adclcd_pkg::Q_W-1:0]        r_bin;
    logic [adclcd_pkg::BCD_W-1:0]      r_bcd;
    logic [adclcd_pkg::CNT_W-1:0]      r_cnt;
    logic [adclcd_pkg::IDX_W-1:0]      r_idx;

    logic [adclcd_pkg::Q_W-1:0]        w_hi;
    logic [adclcd_pkg::PROD_W-1:0]     n_fold;
    logic [adclcd_pkg::BCD_W-1:0]      n_adj;
    logic [adclcd_pkg::BCD_W-1:0]      n_bcd;
    logic [adclcd_pkg::IDX_W-1:0]      w_pos;
    logic [adclcd_pkg::IDX_W-1:0]      w_dig;
    logic [3:0]                        w_nib;

    assign o_pop       = (r_state == ST_IDLE) && i_head.valid;
    assign o_out_valid = (r_state == ST_EMIT);

    // x = 1024*a + b = 1023*a + (a + b): a joins the quotient, a + b remains
    assign w_hi   = r_prod[adclcd_pkg::PROD_W-1:adclcd_pkg::DIV_SH];
    assign n_fold = adclcd_pkg::PROD_W'(w_hi) +
                    adclcd_pkg::PROD_W'(r_prod[adclcd_pkg::DIV_SH-1:0]);

    // Decimal shift-in of the quotient MSB; top carry drops (mod 10^DIGITS)
    always_comb begin
        for (int j = 0; j < adclcd_pkg::DIGITS; j++) begin
            if (r_bcd[4*j +: 4] >= 4'd5) begin
                n_adj[4*j +: 4] = r_bcd[4*j +: 4] + 4'd3;
            end else begin
                n_adj[4*j +: 4] = r_bcd[4*j +: 4];
            end
        end
        n_bcd = {n_adj[adclcd_pkg::BCD_W-2:0], r_bin[adclcd_pkg::Q_W-1]};
    end

    // Beat payload from the write index
    always_comb begin
        w_pos = r_idx - adclcd_pkg::IDX_W'(1);
        if (w_pos < adclcd_pkg::IDX_W'(adclcd_pkg::DOT_POS)) begin
            w_dig = w_pos;
        end else begin
            w_dig = w_pos - adclcd_pkg::IDX_W'(1);
        end
        w_nib = '0;
        for (int j = 0; j < adclcd_pkg::DIGITS; j++) begin
            if (w_dig == adclcd_pkg::IDX_W'(j)) begin
                w_nib = r_bcd[4*(adclcd_pkg::DIGITS-1-j) +: 4];
            end
        end
        o_out_data.last = (r_idx == adclcd_pkg::IDX_W'(adclcd_pkg::N_WRITES - 1));
        if (r_idx == '0) begin
            o_out_data.lcd_byte = adclcd_pkg::HOME_CMD;
            o_out_data.lcd_rs   = 1'b0;
        end else if (w_pos == adclcd_pkg::IDX_W'(adclcd_pkg::DOT_POS)) begin
            o_out_data.lcd_byte = adclcd_pkg::DOT_CHAR;
            o_out_data.lcd_rs   = 1'b1;
        end else begin
            o_out_data.lcd_byte = adclcd_pkg::ZERO_CHAR + {4'd0, w_nib};
            o_out_data.lcd_rs   = 1'b1;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_prod  <= '0;
            r_quo   <= '0;
            r_bin   <= '0;
            r_bcd   <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_prod  <= adclcd_pkg::PROD_W'(i_head.word) *
                                   adclcd_pkg::PROD_W'(adclcd_pkg::SCALE_MUL);
                        r_quo   <= '0;
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    if (w_hi != '0) begin
                        r_quo  <= r_quo + w_hi;
                        r_prod <= n_fold;
                    end else begin
                        // Remainder of exactly 1023 still counts once
                        if (r_prod[adclcd_pkg::DIV_SH-1:0] ==
                            adclcd_pkg::DIV_SH'(adclcd_pkg::SCALE_DIV)) begin
                            r_bin <= r_quo + adclcd_pkg::Q_W'(1);
                        end else begin
                            r_bin <= r_quo;
                        end
                        r_bcd   <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_bin <= {r_bin[adclcd_pkg::Q_W-2:0], 1'b0};
                    r_bcd <= n_bcd;
                    r_cnt <= r_cnt + adclcd_pkg::CNT_W'(1);
                    if (r_cnt == adclcd_pkg::CNT_W'(adclcd_pkg::Q_W - 1)) begin
                        r_idx   <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (i_out_ready) begin
                        if (o_out_data.last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + adclcd_pkg::IDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/adc_word_to_lcd_voltage_readout.sv @@
// ----------------------------------------------------------------------------
// adc_word_to_lcd_voltage_readout
// Converter word from 9-bit serial characters to a decimal display refresh.
// ----------------------------------------------------------------------------
// Each input beat updates one byte of the stored word and produces nine
// display writes: the home command, three digits, a point and four digits,
// the final one flagged by last. In the back end an item is taken from the
// queue while idle and word * 50000 is formed, then the product is folded
// down to its quotient by 1023 (the divisor is 2^10 - 1, so the high part
// is added back onto the low part until it fits), the quotient goes through
// shift-and-add-3 decimal conversion and the writes go out one beat per
// cycle while the display side is ready. A two-entry queue lets up to two
// further input beats be taken while a refresh is in progress.
`timescale 1ns / 1ps
`default_nettype none

module adc_word_to_lcd_voltage_readout (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  adclcd_pkg::t_in_item   i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output adclcd_pkg::t_out_item  o_out_data
);

    adclcd_pkg::t_word_beat w_push;
    adclcd_pkg::t_word_beat w_head;
    logic                   w_full;
    logic                   w_pop;

    adclcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    adclcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    adclcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ design/adclcd_checker.sv @@
// ----------------------------------------------------------------------------
// adclcd_checker
// Port-level checks on the display write stream of the readout block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adclcd_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    o_out_valid,
    input wire                    i_out_ready,
    input adclcd_pkg::t_out_item  o_out_data
);

    // A stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // A refresh run plays out without gaps
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last |=> o_out_valid)
        else $error("gap inside a refresh run");

    // Command writes are only the home command, never flagged last
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.lcd_rs |->
            o_out_data.lcd_byte == adclcd_pkg::HOME_CMD && !o_out_data.last)
        else $error("bad command write");

    // Data writes carry a digit or the point
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.lcd_rs |->
            (o_out_data.lcd_byte >= 8'h30 && o_out_data.lcd_byte <= 8'h39) ||
            o_out_data.lcd_byte == adclcd_pkg::DOT_CHAR)
        else $error("bad data character");

    // The back end needs the full divide before the next run starts
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last |=> !o_out_valid)
        else $error("run started without a conversion");

endmodule

bind adc_word_to_lcd_voltage_readout adclcd_checker u_adclcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
